FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication held on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// Terminal line editor package
// Types, key codes, escape-sequence states and event codes of the editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    // Line store geometry; at most LINE_BYTES-1 bytes form a line.
    localparam int LINE_BYTES = 64;
    localparam int ADDR_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int POS_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int EV_W       = 2;
    localparam int DATA_W     = 24;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam pos_t MAX_LEN = POS_W'(LINE_BYTES - 1);

    // Event codes reported with each result.
    typedef enum logic [EV_W-1:0] {
        EV_EDIT  = 2'd0,
        EV_BELL  = 2'd1,
        EV_BYTE  = 2'd2,
        EV_EMPTY = 2'd3
    } event_t;

    // Received key codes.
    localparam byte_t KEY_CTRL_H   = 8'h08;
    localparam byte_t KEY_TAB      = 8'h09;
    localparam byte_t KEY_LF       = 8'h0a;
    localparam byte_t KEY_KILL     = 8'h0b;
    localparam byte_t KEY_CTRL_L   = 8'h0c;
    localparam byte_t KEY_CR       = 8'h0d;
    localparam byte_t KEY_ESC      = 8'h1b;
    localparam byte_t KEY_SPACE    = 8'h20;
    localparam byte_t KEY_1        = 8'h31;
    localparam byte_t KEY_2        = 8'h32;
    localparam byte_t KEY_3        = 8'h33;
    localparam byte_t KEY_4        = 8'h34;
    localparam byte_t KEY_5        = 8'h35;
    localparam byte_t KEY_6        = 8'h36;
    localparam byte_t KEY_A        = 8'h41;
    localparam byte_t KEY_B        = 8'h42;
    localparam byte_t KEY_C        = 8'h43;
    localparam byte_t KEY_D        = 8'h44;
    localparam byte_t KEY_LBRACKET = 8'h5b;
    localparam byte_t KEY_TILDE    = 8'h7e;
    localparam byte_t KEY_DEL      = 8'h7f;

    // Escape-sequence progress.
    typedef enum logic [3:0] {
        ESC_IDLE = 4'd0,
        ESC_ESC  = 4'd1,
        ESC_CSI  = 4'd2,
        ESC_DEL  = 4'd3,
        ESC_PGUP = 4'd4,
        ESC_PGDN = 4'd5,
        ESC_HOME = 4'd6,
        ESC_END  = 4'd7,
        ESC_INS  = 4'd8
    } esc_t;

    // Request from the sequencer to the line store.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        byte_t wdata;
        addr_t raddr;
    } ram_req_t;

endpackage

FILE: hw/rtl/tle_line_ram.sv
// ----------------------------------------------------------------------------
// Line store
// One write port and one registered read port over the line bytes.
// ----------------------------------------------------------------------------
module tle_line_ram (
    input  logic              clk,
    input  tle_pkg::ram_req_t req,
    output tle_pkg::byte_t    rd_data
);
    import tle_pkg::*;

    byte_t mem [LINE_BYTES];
    byte_t rd_data_reg;

    // Write at the requested address and register the read data.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// Terminal line editor
// An input byte is taken in S_IDLE, decoded in S_DECODE and its result loaded
// to the output from S_DONE. Insert and delete move each byte with a read and
// a write state, then insert stores the new byte in S_PUT. Carriage return
// reads and emits one line byte at a time, waiting while the output drains.
// Reset clears cursor, length, escape state, modes and output valid; the
// line store is not cleared.
// ----------------------------------------------------------------------------
module terminal_line_editor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,  // echo_enable
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tle_pkg::BYTE_W-1:0] s_tdata,     // [7:0] rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [1:0] event_res, [9:2] line_byte, [15:10] cursor_pos,
    // [21:16] line_length, [22] overwrite_on, [23] line_waiting
    output logic [tle_pkg::DATA_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import tle_pkg::*;

    // Sequencer states.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_SHUP_RD = 10'b00_0000_0100,
        S_SHUP_WR = 10'b00_0000_1000,
        S_PUT     = 10'b00_0001_0000,
        S_SHDN_RD = 10'b00_0010_0000,
        S_SHDN_WR = 10'b00_0100_0000,
        S_EMIT_RD = 10'b00_1000_0000,
        S_EMIT_WR = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t   state_reg, state_next;
    byte_t    byte_reg, byte_next;
    pos_t     cursor_reg, cursor_next;
    pos_t     length_reg, length_next;
    esc_t     esc_reg, esc_next;
    logic     ovw_reg, ovw_next;
    logic     echo_reg;
    event_t   ev_reg, ev_next;
    pos_t     idx_reg, idx_next;

    logic     out_valid_reg;
    event_t   out_ev_reg;
    byte_t    out_byte_reg;
    pos_t     out_cur_reg;
    pos_t     out_len_reg;
    logic     out_ovw_reg;
    logic     out_wait_reg;
    logic     out_last_reg;

    logic     out_load;
    event_t   out_ev_c;
    byte_t    out_byte_c;
    pos_t     out_cur_c;
    pos_t     out_len_c;
    logic     out_last_c;
    logic     out_free;
    logic     printable;
    event_t   echo_ev;
    pos_t     raddr_c;
    ram_req_t ram_req;
    byte_t    rd_data;

    assign out_free = !out_valid_reg || m_tready;
    assign echo_ev  = echo_reg ? EV_BELL : EV_EDIT;
    assign s_tready = (state_reg == S_IDLE);

    // Line store.
    tle_line_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Sequencer: decode one byte, then walk the store one entry at a time where a shift or a line send needs it.
    always_comb
    begin
        state_next  = state_reg;
        byte_next   = byte_reg;
        cursor_next = cursor_reg;
        length_next = length_reg;
        esc_next    = esc_reg;
        ovw_next    = ovw_reg;
        ev_next     = ev_reg;
        idx_next    = idx_reg;
        printable   = 1'b0;
        out_load    = 1'b0;
        out_ev_c    = ev_reg;
        out_byte_c  = '0;
        out_cur_c   = cursor_reg;
        out_len_c   = length_reg;
        out_last_c  = 1'b1;
        raddr_c     = idx_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = cursor_reg[ADDR_W-1:0];
        ram_req.wdata = byte_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                ev_next    = EV_EDIT;
                priority if (byte_reg[BYTE_W-1])
                begin
                    ev_next = EV_BELL;
                end
                else if (esc_reg == ESC_IDLE)
                begin
                    unique case (byte_reg)
                        KEY_ESC: esc_next = ESC_ESC;
                        KEY_KILL:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                length_next = cursor_reg;
                            end
                        end
                        KEY_LF, KEY_TAB: ;
                        KEY_CTRL_L:
                        begin
                            if (cursor_reg < length_reg)
                                cursor_next = cursor_reg + 1'b1;
                            else
                                ev_next = echo_ev;
                        end
                        KEY_CTRL_H:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - 1'b1;
                            else
                                ev_next = EV_BELL;
                        end
                        KEY_DEL:
                        begin
                            // Backspace removes the byte left of the cursor.
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                                idx_next    = cursor_reg - 1'b1;
                                if (cursor_reg == length_reg)
                                    length_next = length_reg - 1'b1;
                                else
                                    state_next = S_SHDN_RD;
                            end
                            else
                            begin
                                ev_next = echo_ev;
                            end
                        end
                        KEY_CR:
                        begin
                            cursor_next = '0;
                            if (length_reg == '0)
                            begin
                                ev_next = EV_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_EMIT_RD;
                            end
                        end
                        default: printable = 1'b1;
                    endcase
                end
                else if (esc_reg == ESC_ESC && byte_reg == KEY_LBRACKET)
                begin
                    esc_next = ESC_CSI;
                end
                else if (esc_reg == ESC_CSI && (byte_reg == KEY_A || byte_reg == KEY_B))
                begin
                    esc_next = ESC_IDLE;
                end
                else if (esc_reg == ESC_CSI && byte_reg == KEY_C)
                begin
                    esc_next = ESC_IDLE;
                    if (cursor_reg < length_reg)
                        cursor_next = cursor_reg + 1'b1;
                    else
                        ev_next = echo_ev;
                end
                else if (esc_reg == ESC_CSI && byte_reg == KEY_D)
                begin
                    esc_next = ESC_IDLE;
                    if (cursor_reg != '0)
                        cursor_next = cursor_reg - 1'b1;
                    else
                        ev_next = EV_BELL;
                end
                else if (esc_reg == ESC_CSI && byte_reg == KEY_3) esc_next = ESC_DEL;
                else if (esc_reg == ESC_CSI && byte_reg == KEY_5) esc_next = ESC_PGUP;
                else if (esc_reg == ESC_CSI && byte_reg == KEY_6) esc_next = ESC_PGDN;
                else if (esc_reg == ESC_CSI && byte_reg == KEY_1) esc_next = ESC_HOME;
                else if (esc_reg == ESC_CSI && byte_reg == KEY_4) esc_next = ESC_END;
                else if (esc_reg == ESC_CSI && byte_reg == KEY_2) esc_next = ESC_INS;
                else if ((esc_reg == ESC_DEL || esc_reg == ESC_PGUP || esc_reg == ESC_PGDN ||
                          esc_reg == ESC_HOME || esc_reg == ESC_END || esc_reg == ESC_INS) &&
                         byte_reg == KEY_TILDE)
                begin
                    esc_next = ESC_IDLE;
                    if (esc_reg == ESC_DEL)
                    begin
                        // Delete the byte under the cursor.
                        if (cursor_reg < length_reg)
                        begin
                            idx_next = cursor_reg;
                            if (cursor_reg + 1'b1 == length_reg)
                                length_next = length_reg - 1'b1;
                            else
                                state_next = S_SHDN_RD;
                        end
                        else
                        begin
                            ev_next = echo_ev;
                        end
                    end
                    else if (esc_reg == ESC_HOME)
                        cursor_next = '0;
                    else if (esc_reg == ESC_END)
                        cursor_next = length_reg;
                    else if (esc_reg == ESC_INS)
                        ovw_next = !ovw_reg;
                end
                else
                begin
                    printable = 1'b1;
                end

                // Ordinary byte: control bytes ring when echo is on, others overwrite, or insert if not full.
                if (printable)
                begin
                    esc_next = ESC_IDLE;
                    if (byte_reg < KEY_SPACE)
                    begin
                        ev_next = echo_ev;
                    end
                    else if (cursor_reg < length_reg && ovw_reg)
                    begin
                        ram_req.we  = 1'b1;
                        cursor_next = cursor_reg + 1'b1;
                    end
                    else if (length_reg < MAX_LEN)
                    begin
                        if (cursor_reg == length_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = length_reg - 1'b1;
                            state_next = S_SHUP_RD;
                        end
                    end
                end
            end

            // Move bytes up one place, from the end down to the cursor.
            S_SHUP_RD:
            begin
                state_next = S_SHUP_WR;
            end

            S_SHUP_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(idx_reg + 1'b1);
                ram_req.wdata = rd_data;
                if (idx_reg == cursor_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_SHUP_RD;
                end
            end

            S_PUT:
            begin
                ram_req.we  = 1'b1;
                cursor_next = cursor_reg + 1'b1;
                length_next = length_reg + 1'b1;
                state_next  = S_DONE;
            end

            // Move bytes down one place, from the removed entry to the end.
            S_SHDN_RD:
            begin
                raddr_c    = idx_reg + 1'b1;
                state_next = S_SHDN_WR;
            end

            S_SHDN_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[ADDR_W-1:0];
                ram_req.wdata = rd_data;
                if (idx_reg + 2'd2 == length_reg)
                begin
                    length_next = length_reg - 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SHDN_RD;
                end
            end

            // Send the finished line, one byte per transfer.
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end

            S_EMIT_WR:
            begin
                out_ev_c   = EV_BYTE;
                out_byte_c = rd_data;
                out_cur_c  = '0;
                out_len_c  = '0;
                out_last_c = (idx_reg + 1'b1 == length_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (out_last_c)
                    begin
                        length_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ram_req.raddr = raddr_c[ADDR_W-1:0];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            length_reg    <= '0;
            esc_reg       <= ESC_IDLE;
            ovw_reg       <= 1'b0;
            echo_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            esc_reg    <= esc_next;
            ovw_reg    <= ovw_next;
            if (cfg_wr_en)
            begin
                echo_reg <= cfg_wr_data;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        ev_reg   <= ev_next;
        idx_reg  <= idx_next;
        if (out_load)
        begin
            out_ev_reg   <= out_ev_c;
            out_byte_reg <= out_byte_c;
            out_cur_reg  <= out_cur_c;
            out_len_reg  <= out_len_c;
            out_ovw_reg  <= ovw_reg;
            out_wait_reg <= (out_len_c != '0);
            out_last_reg <= out_last_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_wait_reg, out_ovw_reg, out_len_reg, out_cur_reg,
                       out_byte_reg, out_ev_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/tle_port_checker.sv
// ----------------------------------------------------------------------------
// Terminal line editor port checker
// Watches the result stream of the editor and is bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tle_port_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tle_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast
);
    import tle_pkg::*;

    logic            stalled;
    logic            solo;
    logic [DATA_W:0] beat;
    logic [EV_W-1:0] ev_f;
    byte_t           byte_f;
    pos_t            cur_f;
    pos_t            len_f;
    logic            wait_f;

    // Result fields as packed on the output stream.
    assign ev_f    = m_tdata[1:0];
    assign byte_f  = m_tdata[9:2];
    assign cur_f   = m_tdata[15:10];
    assign len_f   = m_tdata[21:16];
    assign wait_f  = m_tdata[23];
    assign beat    = {m_tlast, m_tdata};
    assign stalled = m_tvalid && !m_tready;
    assign solo    = m_tvalid && ev_f != EV_BYTE;

    // A stalled result holds until its transfer.
    `ASSERT_CLK(a_stall_hold, clk, rst_n, stalled |=> m_tvalid && $stable(beat), "stall broken")

    // The waiting flag follows the reported length.
    `ASSERT_IMPL(a_wait_len, clk, rst_n, m_tvalid, wait_f == (len_f != '0), "bad waiting flag")

    // Only line bytes come in runs; every other event closes its input byte.
    `ASSERT_IMPL(a_single_last, clk, rst_n, solo, m_tlast && byte_f == '0, "stray data or tlast")

    // The cursor never passes the end of the line.
    `ASSERT_IMPL(a_cursor_in_line, clk, rst_n, m_tvalid, cur_f <= len_f, "cursor past line end")

endmodule

bind terminal_line_editor tle_port_checker u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
